FILE: src/timestamped_stereo_frame_fifo_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped stereo frame FIFO
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_STEREO_FRAME_FIFO_TOP_MACROS_SVH
`define TIMESTAMPED_STEREO_FRAME_FIFO_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define TSF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define TSF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TSF_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define TSF_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/tsfifo_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped stereo frame FIFO package
// Sizes, operation and status codes, and controller to datapath types.
// ----------------------------------------------------------------------------
package tsfifo_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int MAX_READ = 64;
    localparam int CNT_W    = $clog2(MAX_READ + 1);
    localparam int LEN_W    = 16;
    localparam int LIMIT_W  = 7;
    localparam int FILL_W   = 11;
    localparam int CMP_W    = LEN_W + PTR_W;

    localparam logic [2:0] OP_WRITE_BEGIN = 3'd0;
    localparam logic [2:0] OP_WRITE_FRAME = 3'd1;
    localparam logic [2:0] OP_READ        = 3'd2;
    localparam logic [2:0] OP_PACKET_READ = 3'd3;
    localparam logic [2:0] OP_CLEAR       = 3'd4;
    localparam logic [2:0] OP_QUERY       = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_NO_BURST = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [3:0] DP_NONE         = 4'd0;
    localparam logic [3:0] DP_SINGLE       = 4'd1;
    localparam logic [3:0] DP_READ_BEGIN   = 4'd2;
    localparam logic [3:0] DP_CAPTURE      = 4'd3;
    localparam logic [3:0] DP_CAPTURE_SCAN = 4'd4;
    localparam logic [3:0] DP_SCAN_NEXT    = 4'd5;
    localparam logic [3:0] DP_SCAN_END     = 4'd6;
    localparam logic [3:0] DP_REWIND       = 4'd7;
    localparam logic [3:0] DP_EMIT         = 4'd8;
    localparam logic [3:0] DP_EMIT_END     = 4'd9;

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic read_go;
        logic packet;
        logic multi;
        logic match;
        logic more;
        logic last;
    } dp_stat_t;

endpackage

FILE: src/tsfifo_ram.sv
// ----------------------------------------------------------------------------
// Generic dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsfifo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/tsfifo_ctrl.sv
// ----------------------------------------------------------------------------
// Timestamped stereo frame FIFO controller
// Sequences single-result operations, the packet scan and frame delivery.
// ----------------------------------------------------------------------------
module tsfifo_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  tsfifo_pkg::dp_stat_t stat,
    output tsfifo_pkg::dp_cmd_t  cmd
);
    import tsfifo_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIRST  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_REWIND = 3'd3;
    localparam logic [2:0] S_DLV    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NONE;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = stat.out_free;
                if (item_valid && stat.out_free)
                begin
                    if (stat.read_go)
                    begin
                        cmd.op     = DP_READ_BEGIN;
                        state_next = S_FIRST;
                    end
                    else
                    begin
                        cmd.op = DP_SINGLE;
                    end
                end
            end
            S_FIRST:
            begin
                if (stat.packet && stat.multi)
                begin
                    cmd.op     = DP_CAPTURE_SCAN;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.op     = DP_CAPTURE;
                    state_next = S_DLV;
                end
            end
            S_SCAN:
            begin
                if (stat.match && stat.more)
                begin
                    cmd.op = DP_SCAN_NEXT;
                end
                else
                begin
                    cmd.op     = DP_SCAN_END;
                    state_next = S_REWIND;
                end
            end
            S_REWIND:
            begin
                cmd.op     = DP_REWIND;
                state_next = S_DLV;
            end
            S_DLV:
            begin
                if (stat.out_free)
                begin
                    if (stat.last)
                    begin
                        cmd.op     = DP_EMIT_END;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.op = DP_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/tsfifo_dp.sv
// ----------------------------------------------------------------------------
// Timestamped stereo frame FIFO datapath
// Ring pointers, burst bookkeeping, frame and stamp memories, result register.
// ----------------------------------------------------------------------------
module tsfifo_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsfifo_pkg::dp_cmd_t             cmd,
    output tsfifo_pkg::dp_stat_t            stat,
    input  logic [2:0]                      opcode,
    input  logic [31:0]                     left_sample,
    input  logic [31:0]                     right_sample,
    input  logic [63:0]                     stamp,
    input  logic [tsfifo_pkg::LEN_W-1:0]    burst_length,
    input  logic [tsfifo_pkg::LIMIT_W-1:0]  read_limit,
    input  logic                            result_ready,
    output logic                            result_valid,
    output logic [31:0]                     left_out,
    output logic [31:0]                     right_out,
    output logic [63:0]                     stamp_out,
    output logic                            frame_valid,
    output logic                            last,
    output logic [1:0]                      status,
    output logic [tsfifo_pkg::FILL_W-1:0]   fill_level,
    output logic [63:0]                     dropped_total
);
    import tsfifo_pkg::*;

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [63:0]       dropped_reg, dropped_next;
    logic [LEN_W-1:0]  burst_left_reg, burst_left_next;
    logic [PTR_W-1:0]  burst_stored_reg, burst_stored_next;
    logic [63:0]       burst_stamp_reg, burst_stamp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              packet_reg, packet_next;
    logic [63:0]       first_stamp_reg, first_stamp_next;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       left_reg, left_next;
    logic [31:0]       right_reg, right_next;
    logic [63:0]       stamp_out_reg, stamp_out_next;
    logic              frame_valid_reg, frame_valid_next;
    logic              last_reg, last_next;
    logic [1:0]        status_reg, status_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [63:0]       dropped_out_reg, dropped_out_next;

    logic [PTR_W-1:0]  fill;
    logic [PTR_W-1:0]  free;
    logic [CNT_W-1:0]  lim_sat;
    logic [CNT_W-1:0]  count_in;
    logic              is_read;
    logic              out_free;
    logic              out_load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [63:0]       sample_rdata;
    logic [63:0]       stamp_rdata;

    always_comb
    begin
        fill     = wr_ptr_reg - rd_ptr_reg;
        free     = PTR_W'(DEPTH) - fill;
        lim_sat  = (read_limit > LIMIT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : CNT_W'(read_limit);
        count_in = (PTR_W'(lim_sat) > fill) ? CNT_W'(fill) : lim_sat;
        is_read  = (opcode == OP_READ) || (opcode == OP_PACKET_READ);
        out_free = !out_valid_reg || result_ready;

        stat.out_free = out_free;
        stat.read_go  = is_read && (count_in != '0);
        stat.packet   = packet_reg;
        stat.multi    = cnt_reg > CNT_W'(1);
        stat.match    = stamp_rdata == first_stamp_reg;
        stat.more     = (idx_reg + CNT_W'(1)) < cnt_reg;
        stat.last     = (idx_reg + CNT_W'(1)) == cnt_reg;
    end

    always_comb
    begin
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        dropped_next      = dropped_reg;
        burst_left_next   = burst_left_reg;
        burst_stored_next = burst_stored_reg;
        burst_stamp_next  = burst_stamp_reg;
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        packet_next       = packet_reg;
        first_stamp_next  = first_stamp_reg;

        out_load          = 1'b0;
        left_next         = left_reg;
        right_next        = right_reg;
        stamp_out_next    = stamp_out_reg;
        frame_valid_next  = frame_valid_reg;
        last_next         = last_reg;
        status_next       = status_reg;
        fill_next         = fill_reg;
        dropped_out_next  = dropped_out_reg;

        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(wr_ptr_reg + burst_stored_reg);
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(rd_ptr_reg);

        unique case (cmd.op) inside
            DP_SINGLE:
            begin
                status_next = ST_OK;
                case (opcode) inside
                    OP_WRITE_BEGIN:
                    begin
                        burst_left_next   = '0;
                        burst_stored_next = '0;
                        if (CMP_W'(burst_length) > CMP_W'(free))
                        begin
                            dropped_next = dropped_reg + 64'(burst_length);
                            status_next  = ST_REFUSED;
                        end
                        else
                        begin
                            burst_left_next  = burst_length;
                            burst_stamp_next = stamp;
                        end
                    end
                    OP_WRITE_FRAME:
                    begin
                        if (burst_left_reg == '0)
                        begin
                            status_next = ST_NO_BURST;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            burst_left_next = burst_left_reg - LEN_W'(1);
                            if (burst_left_reg == LEN_W'(1))
                            begin
                                wr_ptr_next       = wr_ptr_reg + burst_stored_reg + PTR_W'(1);
                                burst_stored_next = '0;
                            end
                            else
                            begin
                                burst_stored_next = burst_stored_reg + PTR_W'(1);
                            end
                        end
                    end
                    OP_READ, OP_PACKET_READ:
                    begin
                        status_next = ST_EMPTY;
                    end
                    OP_CLEAR:
                    begin
                        rd_ptr_next = wr_ptr_reg;
                    end
                    default:
                    begin
                    end
                endcase
                out_load         = 1'b1;
                left_next        = '0;
                right_next       = '0;
                stamp_out_next   = '0;
                frame_valid_next = 1'b0;
                last_next        = 1'b1;
                fill_next        = FILL_W'(wr_ptr_next - rd_ptr_next);
                dropped_out_next = dropped_next;
            end
            DP_READ_BEGIN:
            begin
                cnt_next    = count_in;
                packet_next = opcode == OP_PACKET_READ;
                ram_re      = 1'b1;
            end
            DP_CAPTURE:
            begin
                first_stamp_next = stamp_rdata;
                idx_next         = '0;
            end
            DP_CAPTURE_SCAN:
            begin
                first_stamp_next = stamp_rdata;
                idx_next         = CNT_W'(1);
                ram_re           = 1'b1;
                ram_raddr        = ADDR_W'(rd_ptr_reg + PTR_W'(1));
            end
            DP_SCAN_NEXT:
            begin
                idx_next  = idx_reg + CNT_W'(1);
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(rd_ptr_reg + PTR_W'(idx_reg) + PTR_W'(1));
            end
            DP_SCAN_END:
            begin
                if (!stat.match)
                begin
                    cnt_next = idx_reg;
                end
            end
            DP_REWIND:
            begin
                idx_next = '0;
                ram_re   = 1'b1;
            end
            DP_EMIT, DP_EMIT_END:
            begin
                out_load         = 1'b1;
                left_next        = sample_rdata[31:0];
                right_next       = sample_rdata[63:32];
                stamp_out_next   = first_stamp_reg;
                frame_valid_next = 1'b1;
                last_next        = cmd.op == DP_EMIT_END;
                status_next      = ST_OK;
                fill_next        = FILL_W'(wr_ptr_reg - rd_ptr_reg - PTR_W'(cnt_reg));
                dropped_out_next = dropped_reg;
                if (cmd.op == DP_EMIT_END)
                begin
                    rd_ptr_next = rd_ptr_reg + PTR_W'(cnt_reg);
                end
                else
                begin
                    idx_next  = idx_reg + CNT_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(rd_ptr_reg + PTR_W'(idx_reg) + PTR_W'(1));
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            dropped_reg      <= '0;
            burst_left_reg   <= '0;
            burst_stored_reg <= '0;
            burst_stamp_reg  <= '0;
            cnt_reg          <= '0;
            idx_reg          <= '0;
            packet_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            dropped_reg      <= dropped_next;
            burst_left_reg   <= burst_left_next;
            burst_stored_reg <= burst_stored_next;
            burst_stamp_reg  <= burst_stamp_next;
            cnt_reg          <= cnt_next;
            idx_reg          <= idx_next;
            packet_reg       <= packet_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_stamp_reg <= first_stamp_next;
        left_reg        <= left_next;
        right_reg       <= right_next;
        stamp_out_reg   <= stamp_out_next;
        frame_valid_reg <= frame_valid_next;
        last_reg        <= last_next;
        status_reg      <= status_next;
        fill_reg        <= fill_next;
        dropped_out_reg <= dropped_out_next;
    end

    tsfifo_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({right_sample, left_sample}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (sample_rdata)
    );

    tsfifo_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (burst_stamp_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (stamp_rdata)
    );

    assign result_valid  = out_valid_reg;
    assign left_out      = left_reg;
    assign right_out     = right_reg;
    assign stamp_out     = stamp_out_reg;
    assign frame_valid   = frame_valid_reg;
    assign last          = last_reg;
    assign status        = status_reg;
    assign fill_level    = fill_reg;
    assign dropped_total = dropped_out_reg;

endmodule

FILE: src/timestamped_stereo_frame_fifo_top.sv
// ----------------------------------------------------------------------------
// Timestamped stereo frame FIFO
// Ring buffer of stereo frames, each tagged with the stamp of its burst.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the item channel (item_valid / item_ready) and
// results leave on the result channel (result_valid / result_ready); each
// channel moves one word per handshake. Write begin, write frame, clear,
// query and a read that finds nothing give one word each, taken at one per
// cycle unless the receiver stalls; the word appears in the cycle after
// acceptance. A read of N frames gives N words: the block reads the first
// frame and its stamp, then emits one word per cycle unless the receiver
// stalls, paced by the single read port of the frame and stamp memories.
// A packet read of more than one candidate first scans the stamps, one per
// cycle, and then rereads the frames. The next command is taken no earlier
// than the cycle in which the last word of a read leaves the output
// register. When the receiver stalls the output register holds its word
// and the block waits; nothing is lost. Reset empties the FIFO, closes any
// burst and clears the dropped total at once; the memories are not cleared.
// ----------------------------------------------------------------------------
`include "timestamped_stereo_frame_fifo_top_macros.svh"

module timestamped_stereo_frame_fifo_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [2:0]                      opcode,
    input  logic [31:0]                     left_sample,
    input  logic [31:0]                     right_sample,
    input  logic [63:0]                     stamp,
    input  logic [tsfifo_pkg::LEN_W-1:0]    burst_length,
    input  logic [tsfifo_pkg::LIMIT_W-1:0]  read_limit,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [31:0]                     left_out,
    output logic [31:0]                     right_out,
    output logic [63:0]                     stamp_out,
    output logic                            frame_valid,
    output logic                            last,
    output logic [1:0]                      status,
    output logic [tsfifo_pkg::FILL_W-1:0]   fill_level,
    output logic [63:0]                     dropped_total
);
    import tsfifo_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tsfifo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    tsfifo_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .stamp         (stamp),
        .burst_length  (burst_length),
        .read_limit    (read_limit),
        .result_ready  (result_ready),
        .result_valid  (result_valid),
        .left_out      (left_out),
        .right_out     (right_out),
        .stamp_out     (stamp_out),
        .frame_valid   (frame_valid),
        .last          (last),
        .status        (status),
        .fill_level    (fill_level),
        .dropped_total (dropped_total)
    );

    `TSF_ASSERT_IMP(a_fill_bound, clk, rst_n, result_valid, fill_level <= FILL_W'(DEPTH))
    `TSF_ASSERT_IMP(a_frame_ok, clk, rst_n, result_valid && frame_valid, status == ST_OK)
    `TSF_ASSERT_IMP(a_single_last, clk, rst_n, result_valid && !frame_valid, last)
    `TSF_ASSERT_NEXT(a_take_idle, clk, rst_n, item_valid && item_ready && !stat.read_go, result_valid)

endmodule

FILE: test/timestamped_stereo_frame_fifo_top_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the timestamped stereo frame FIFO
// Drives commands through the item channel and checks every result word
// against a cycle-free model of the ring, its burst commit and its reads.
// A short table of directed commands comes first, then random bursts, reads
// and noise under three mixes of sender and receiver stalls.
// ----------------------------------------------------------------------------
module timestamped_stereo_frame_fifo_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsfifo_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 26;

    typedef struct packed {
        logic [31:0]       left;
        logic [31:0]       right;
        logic [63:0]       stamp;
        logic              valid;
        logic              last;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill;
        logic [63:0]       dropped;
    } result_word_t;

    typedef struct {
        logic [2:0]        op;
        logic [31:0]       l;
        logic [31:0]       r;
        logic [63:0]       s;
        logic [15:0]       len;
        logic [6:0]        lim;
        bit                typed;
        logic [1:0]        st;
        logic [FILL_W-1:0] fill;
        logic [63:0]       dropped;
    } cmd_row_t;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    logic [2:0]          opcode       = 3'd0;
    logic [31:0]         left_sample  = 32'd0;
    logic [31:0]         right_sample = 32'd0;
    logic [63:0]         stamp        = 64'd0;
    logic [LEN_W-1:0]    burst_length = '0;
    logic [LIMIT_W-1:0]  read_limit   = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [31:0]         left_out;
    logic [31:0]         right_out;
    logic [63:0]         stamp_out;
    logic                frame_valid;
    logic                last;
    logic [1:0]          status;
    logic [FILL_W-1:0]   fill_level;
    logic [63:0]         dropped_total;

    // Model of the ring.
    logic [63:0] frame_mem [DEPTH];
    logic [63:0] tag_mem [DEPTH];
    logic [63:0] wr_total     = 64'd0;
    logic [63:0] rd_total     = 64'd0;
    logic [63:0] drop_total   = 64'd0;
    logic [16:0] burst_left   = 17'd0;
    logic [16:0] burst_stored = 17'd0;
    logic [63:0] burst_tag    = 64'd0;

    result_word_t words_due [$];
    result_word_t got_word;
    result_word_t want_word;
    logic [63:0]  stamp_pool [4];
    int           mismatch_count = 0;
    int           items_sent     = 0;
    int           cycle_count    = 0;
    int           snd_idle       = 0;
    int           rcv_idle       = 0;
    int           phase_end;

    cmd_row_t directed_cmds [N_DIRECTED] = '{
        '{OP_READ,        32'h0, 32'h0, 64'h0, 16'd0, 7'd5,   1'b1, ST_EMPTY, 11'd0, 64'd0},
        '{OP_PACKET_READ, 32'h0, 32'h0, 64'h0, 16'd0, 7'd64,  1'b1, ST_EMPTY, 11'd0, 64'd0},
        '{OP_WRITE_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 16'd0, 7'd0,
          1'b1, ST_NO_BURST, 11'd0, 64'd0},
        '{OP_WRITE_BEGIN, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 7'd0,
          1'b1, ST_REFUSED, 11'd0, 64'd65535},
        '{OP_WRITE_BEGIN, 32'h0, 32'h0, 64'h0, 16'd0, 7'd0, 1'b1, ST_OK, 11'd0, 64'd65535},
        '{OP_WRITE_FRAME, 32'h1234_5678, 32'h9ABC_DEF0, 64'h0, 16'd0, 7'd0,
          1'b1, ST_NO_BURST, 11'd0, 64'd65535},
        '{OP_WRITE_BEGIN, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd3, 7'd0,
          1'b1, ST_OK, 11'd0, 64'd65535},
        '{OP_WRITE_FRAME, 32'h0, 32'h0, 64'h0, 16'd0, 7'd0, 1'b1, ST_OK, 11'd0, 64'd65535},
        '{OP_WRITE_FRAME, 32'hFFFF_FFFF, 32'h0, 64'h0, 16'd0, 7'd0,
          1'b1, ST_OK, 11'd0, 64'd65535},
        '{OP_WRITE_FRAME, 32'h0, 32'hFFFF_FFFF, 64'h0, 16'd0, 7'd0,
          1'b1, ST_OK, 11'd3, 64'd65535},
        '{OP_WRITE_BEGIN, 32'h0, 32'h0, 64'h0, 16'd2, 7'd0, 1'b1, ST_OK, 11'd3, 64'd65535},
        '{OP_WRITE_FRAME, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 64'h0, 16'd0, 7'd0,
          1'b1, ST_OK, 11'd3, 64'd65535},
        '{OP_WRITE_FRAME, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 64'h0, 16'd0, 7'd0,
          1'b1, ST_OK, 11'd5, 64'd65535},
        '{OP_PACKET_READ, 32'h0, 32'h0, 64'h0, 16'd0, 7'd64,  1'b0, ST_OK, 11'd0, 64'd0},
        '{OP_READ,        32'h0, 32'h0, 64'h0, 16'd0, 7'd0,
          1'b1, ST_EMPTY, 11'd2, 64'd65535},
        '{OP_READ,        32'h0, 32'h0, 64'h0, 16'd0, 7'd1,   1'b0, ST_OK, 11'd0, 64'd0},
        '{OP_WRITE_BEGIN, 32'h0, 32'h0, 64'h0123_4567_89AB_CDEF, 16'd3, 7'd0,
          1'b1, ST_OK, 11'd1, 64'd65535},
        '{OP_WRITE_FRAME, 32'h1111_1111, 32'h2222_2222, 64'h0, 16'd0, 7'd0,
          1'b1, ST_OK, 11'd1, 64'd65535},
        '{OP_WRITE_BEGIN, 32'h0, 32'h0, 64'hFEDC_BA98_7654_3210, 16'd2, 7'd0,
          1'b1, ST_OK, 11'd1, 64'd65535},
        '{OP_WRITE_FRAME, 32'h3333_3333, 32'h4444_4444, 64'h0, 16'd0, 7'd0,
          1'b1, ST_OK, 11'd1, 64'd65535},
        '{OP_CLEAR,       32'h0, 32'h0, 64'h0, 16'd0, 7'd0, 1'b1, ST_OK, 11'd0, 64'd65535},
        '{OP_WRITE_FRAME, 32'h5555_5555, 32'h6666_6666, 64'h0, 16'd0, 7'd0,
          1'b1, ST_OK, 11'd2, 64'd65535},
        '{OP_SPARE_6,     32'h0, 32'h0, 64'h0, 16'd0, 7'd0, 1'b1, ST_OK, 11'd2, 64'd65535},
        '{OP_SPARE_7,     32'h0, 32'h0, 64'h0, 16'd0, 7'd0, 1'b1, ST_OK, 11'd2, 64'd65535},
        '{OP_WRITE_BEGIN, 32'h0, 32'h0, 64'h0, 16'd1023, 7'd0,
          1'b1, ST_REFUSED, 11'd2, 64'd66558},
        '{OP_PACKET_READ, 32'h0, 32'h0, 64'h0, 16'd0, 7'd127, 1'b0, ST_OK, 11'd0, 64'd0}
    };

    timestamped_stereo_frame_fifo_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (opcode),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .stamp         (stamp),
        .burst_length  (burst_length),
        .read_limit    (read_limit),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .left_out      (left_out),
        .right_out     (right_out),
        .stamp_out     (stamp_out),
        .frame_valid   (frame_valid),
        .last          (last),
        .status        (status),
        .fill_level    (fill_level),
        .dropped_total (dropped_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic apply_command(input logic [2:0] op, input logic [31:0] l,
                                 input logic [31:0] r, input logic [63:0] s,
                                 input logic [15:0] len, input logic [6:0] lim,
                                 input bit keep);
        logic [63:0]       fill;
        logic [63:0]       cnt;
        logic [63:0]       first;
        logic [63:0]       tag;
        logic [63:0]       n;
        logic [ADDR_W-1:0] ix;
        logic [1:0]        st;
        result_word_t      w;
        fill = wr_total - rd_total;
        st = ST_OK;
        case (op) inside
            OP_WRITE_BEGIN:
            begin
                burst_left = 17'd0;
                burst_stored = 17'd0;
                if ({48'd0, len} > 64'(DEPTH) - fill)
                begin
                    drop_total = drop_total + {48'd0, len};
                    st = ST_REFUSED;
                end
                else
                begin
                    burst_left = {1'b0, len};
                    burst_tag = s;
                end
            end
            OP_WRITE_FRAME:
            begin
                if (burst_left == 17'd0)
                begin
                    st = ST_NO_BURST;
                end
                else
                begin
                    ix = ADDR_W'(wr_total + {47'd0, burst_stored});
                    frame_mem[ix] = {r, l};
                    tag_mem[ix] = burst_tag;
                    burst_stored = burst_stored + 17'd1;
                    burst_left = burst_left - 17'd1;
                    if (burst_left == 17'd0)
                    begin
                        wr_total = wr_total + {47'd0, burst_stored};
                        burst_stored = 17'd0;
                    end
                end
            end
            OP_READ, OP_PACKET_READ:
            begin
                cnt = (lim > MAX_READ) ? 64'(MAX_READ) : {57'd0, lim};
                if (cnt > fill)
                    cnt = fill;
                if (cnt == 64'd0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    first = rd_total;
                    tag = tag_mem[ADDR_W'(first)];
                    if (op == OP_PACKET_READ)
                    begin
                        n = 64'd0;
                        while (n < cnt && tag_mem[ADDR_W'(first + n)] == tag)
                            n = n + 64'd1;
                        cnt = n;
                    end
                    rd_total = first + cnt;
                    if (keep)
                    begin
                        for (n = 64'd0; n < cnt; n = n + 64'd1)
                        begin
                            w.left = frame_mem[ADDR_W'(first + n)][31:0];
                            w.right = frame_mem[ADDR_W'(first + n)][63:32];
                            w.stamp = tag;
                            w.valid = 1'b1;
                            w.last = (n + 64'd1 == cnt);
                            w.status = ST_OK;
                            w.fill = FILL_W'(wr_total - rd_total);
                            w.dropped = drop_total;
                            words_due.push_back(w);
                        end
                    end
                    return;
                end
            end
            OP_CLEAR:
            begin
                rd_total = wr_total;
            end
            default:
            begin
            end
        endcase
        if (keep)
        begin
            w = '0;
            w.last = 1'b1;
            w.status = st;
            w.fill = FILL_W'(wr_total - rd_total);
            w.dropped = drop_total;
            words_due.push_back(w);
        end
    endtask

    task automatic send_word(input logic [2:0] op, input logic [31:0] l,
                             input logic [31:0] r, input logic [63:0] s,
                             input logic [15:0] len, input logic [6:0] lim,
                             input bit keep);
        int gap;
        if ($urandom_range(99) < snd_idle)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        opcode <= op;
        left_sample <= l;
        right_sample <= r;
        stamp <= s;
        burst_length <= len;
        read_limit <= lim;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        apply_command(op, l, r, s, len, lim, keep);
    endtask

    task automatic random_sequence();
        logic [31:0] l;
        logic [31:0] r;
        logic [63:0] s;
        logic [15:0] len;
        logic [6:0]  lim;
        int          kind;
        int          n;
        l = $urandom();
        r = $urandom();
        s = {$urandom(), $urandom()};
        len = 16'($urandom());
        lim = 7'($urandom_range(0, 127));
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            len = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            if ($urandom_range(9) < 7)
                s = stamp_pool[2'($urandom_range(0, 3))];
            send_word(OP_WRITE_BEGIN, l, r, s, len, lim, 1'b1);
            n = int'(len);
            if (len > 1 && $urandom_range(99) < 15)
                n = $urandom_range(0, len - 1);
            repeat (n)
                send_word(OP_WRITE_FRAME, $urandom(), $urandom(), {$urandom(), $urandom()},
                          16'($urandom()), 7'($urandom()), 1'b1);
        end
        else if (kind < 55)
            send_word(OP_WRITE_BEGIN, l, r, s, len, lim, 1'b1);
        else if (kind < 75)
            send_word(OP_READ, l, r, s, len, lim, 1'b1);
        else if (kind < 88)
            send_word(OP_PACKET_READ, l, r, s, len, lim, 1'b1);
        else if (kind < 92)
            send_word(OP_CLEAR, l, r, s, len, lim, 1'b1);
        else if (kind < 95)
            send_word(OP_QUERY, l, r, s, len, lim, 1'b1);
        else
            send_word(3'($urandom_range(0, 7)), l, r, s, len, lim, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            got_word = '{left_out, right_out, stamp_out, frame_valid, last, status,
                         fill_level, dropped_total};
            if (words_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: left %h right %h stamp %h valid %b",
                             got_word.left, got_word.right, got_word.stamp, got_word.valid);
            end
            else
            begin
                want_word = words_due.pop_front();
                if (got_word.left !== want_word.left || got_word.right !== want_word.right ||
                    got_word.stamp !== want_word.stamp || got_word.valid !== want_word.valid ||
                    got_word.last !== want_word.last || got_word.status !== want_word.status ||
                    got_word.fill !== want_word.fill || got_word.dropped !== want_word.dropped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch, expected: left %h right %h stamp %h valid %b",
                                 want_word.left, want_word.right, want_word.stamp,
                                 want_word.valid);
                        $display("    last %b status %0d fill %0d dropped %0d",
                                 want_word.last, want_word.status, want_word.fill,
                                 want_word.dropped);
                        $display("  actual: left %h right %h stamp %h valid %b",
                                 got_word.left, got_word.right, got_word.stamp,
                                 got_word.valid);
                        $display("    last %b status %0d fill %0d dropped %0d",
                                 got_word.last, got_word.status, got_word.fill,
                                 got_word.dropped);
                    end
                end
            end
        end
        result_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        cmd_row_t row;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        snd_idle = 19;
        rcv_idle = 62;
        foreach (directed_cmds[i])
        begin
            row = directed_cmds[i];
            send_word(row.op, row.l, row.r, row.s, row.len, row.lim, !row.typed);
            if (row.typed)
                words_due.push_back('{32'd0, 32'd0, 64'd0, 1'b0, 1'b1, row.st, row.fill,
                                      row.dropped});
        end

        foreach (stamp_pool[i])
            stamp_pool[i] = {$urandom(), $urandom()};
        phase_end = items_sent + 50;
        while (items_sent < phase_end)
            random_sequence();

        snd_idle = 62;
        rcv_idle = 19;
        phase_end = items_sent + 50;
        while (items_sent < phase_end)
            random_sequence();

        snd_idle = 0;
        rcv_idle = 0;
        phase_end = items_sent + 50;
        while (items_sent < phase_end)
            random_sequence();
        item_valid <= 1'b0;

        while (words_due.size() != 0)
            @(posedge clk);
        repeat (4 * MAX_READ) @(posedge clk);
        if (mismatch_count == 0 && words_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
